// ===== src/qnorm_pkg.sv =====
// shared widths for the quaternion normalize pipeline
package qnorm_pkg;
    localparam int NW = 25;   // norm width, floor(sqrt(S * 2^16))
    localparam int XW = 30;   // magnitude entering the final scale divider
    localparam int TW = 17;   // quotient bits of the final scale divider
endpackage

// ===== src/quaternion_normalize_with_gradient_top.sv =====
// top level: quaternion normalize and gradient, fully pipelined
//
// channel      | dir | handshake                          | payload
// s_axis       | in  | i_s_axis_tvalid / o_s_axis_tready  | q, g in tdata, op in tuser, tlast
// m_axis       | out | o_m_axis_tvalid / i_m_axis_tready  | r in tdata, flags in tuser, tlast
// grad_enable  | in  | i_grad_enable_we                   | i_grad_enable
//
// one request per cycle while the output register is not held
// the 25-step norm sqrt runs overlapped with the 31-step gradient
//   divider, followed by the 17-step scale divider
// all stages share one enable: the pipeline moves when the output register is free
// synchronous active-low reset clears valid bits and sets grad_enable to 1
// backward requests with grad_enable low are accepted and dropped
module quaternion_normalize_with_gradient_top
    import qnorm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_grad_enable_we,
    input  logic          i_grad_enable,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // q_w, q_x, q_y, q_z, g_w, g_x, g_y, g_z
    input  logic          i_s_axis_tuser,   // op
    input  logic          i_s_axis_tlast,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata,   // r_w, r_x, r_y, r_z
    output logic [1:0]    o_m_axis_tuser,   // zero_norm, saturated
    output logic          o_m_axis_tlast
);
    localparam int DSTEPS = 31;   // quotient bits of the gradient divider
    localparam int SSTEPS = NW;   // root bits of the norm sqrt
    localparam int CDLY   = TW + 2;

    // middle section: gradient divider and norm sqrt side by side
    typedef struct packed {
        logic                   vld;
        logic                   op;
        logic                   last;
        logic                   zero;
        logic [32:0]            s;
        logic [NW-1:0]          root;
        logic [26:0]            srem;
        logic [49:0]            rad;
        logic [3:0]             qneg;
        logic [3:0]             dneg;
        logic [3:0][15:0]       qmag;
        logic [3:0][32:0]       rem;
        logic [3:0][30:0]       nlo;
        logic [3:0][30:0]       t1;
    } t_mid;

    typedef struct packed {
        logic vld;
        logic last;
        logic zero;
    } t_ctl;

    logic w_ce;
    logic r_grad_en;

    // stage a: input request
    logic                r_a_vld, r_a_op, r_a_last;
    logic signed [15:0]  r_a_q [4];
    logic signed [15:0]  r_a_g [4];
    // stage b: squares and cross products
    logic                r_b_vld, r_b_op, r_b_last;
    logic signed [15:0]  r_b_q [4];
    logic signed [15:0]  r_b_g [4];
    logic [31:0]         r_b_sq [4];
    logic signed [31:0]  r_b_qg [4];
    // stage c: S = sum q^2, P = sum q g
    logic                r_c_vld, r_c_op, r_c_last;
    logic signed [15:0]  r_c_q [4];
    logic signed [15:0]  r_c_g [4];
    logic [32:0]         r_c_s;
    logic signed [33:0]  r_c_p;
    // stage d: g S and q P
    logic                r_d_vld, r_d_op, r_d_last;
    logic signed [15:0]  r_d_q [4];
    logic [32:0]         r_d_s;
    logic signed [49:0]  r_d_gs [4];
    logic signed [49:0]  r_d_qp [4];

    t_mid r_m [0:DSTEPS];
    t_ctl r_c_dly [0:CDLY-1];

    logic signed [15:0] w_r [4];
    logic [3:0]         w_clip;

    // output register empty or being drained
    assign w_ce = !r_c_dly[CDLY-1].vld || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grad_en <= 1'b1;
        end else if (i_grad_enable_we) begin
            r_grad_en <= i_grad_enable;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_ce) begin
            // drop backward requests while gradients are off
            r_a_vld <= i_s_axis_tvalid && (!i_s_axis_tuser || r_grad_en);
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    // front payload
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_op   <= i_s_axis_tuser;
            r_a_last <= i_s_axis_tlast;
            for (int j = 0; j < 4; j++) begin
                r_a_q[j] <= $signed(i_s_axis_tdata[16*j +: 16]);
                r_a_g[j] <= $signed(i_s_axis_tdata[64 + 16*j +: 16]);
            end
            r_b_op   <= r_a_op;
            r_b_last <= r_a_last;
            for (int j = 0; j < 4; j++) begin
                r_b_q[j]  <= r_a_q[j];
                r_b_g[j]  <= r_a_g[j];
                r_b_sq[j] <= 32'(r_a_q[j] * r_a_q[j]);
                r_b_qg[j] <= r_a_q[j] * r_a_g[j];
            end
            r_c_op   <= r_b_op;
            r_c_last <= r_b_last;
            for (int j = 0; j < 4; j++) begin
                r_c_q[j] <= r_b_q[j];
                r_c_g[j] <= r_b_g[j];
            end
            r_c_s <= {1'b0, r_b_sq[0]} + {1'b0, r_b_sq[1]}
                   + {1'b0, r_b_sq[2]} + {1'b0, r_b_sq[3]};
            r_c_p <= 34'(r_b_qg[0]) + 34'(r_b_qg[1]) + 34'(r_b_qg[2]) + 34'(r_b_qg[3]);
            r_d_op   <= r_c_op;
            r_d_last <= r_c_last;
            r_d_s    <= r_c_s;
            for (int j = 0; j < 4; j++) begin
                r_d_q[j]  <= r_c_q[j];
                r_d_gs[j] <= 50'(r_c_g[j]) * $signed({17'b0, r_c_s});
                r_d_qp[j] <= 50'(r_c_q[j]) * 50'(r_c_p);
            end
        end
    end

    // entry of the middle section: numerator magnitudes and sqrt radicand
    t_mid w_m0;
    always_comb begin
        logic signed [50:0] dd;
        logic [50:0]        dmag;
        logic [16:0]        qm;
        w_m0      = '0;
        w_m0.vld  = r_d_vld;
        w_m0.op   = r_d_op;
        w_m0.last = r_d_last;
        w_m0.zero = (r_d_s == 33'd0);
        w_m0.s    = r_d_s;
        w_m0.rad  = {1'b0, r_d_s, 16'b0};
        for (int j = 0; j < 4; j++) begin
            dd   = 51'(r_d_gs[j]) - 51'(r_d_qp[j]);
            dmag = dd[50] ? 51'(-dd) : 51'(dd);
            qm   = r_d_q[j][15] ? 17'(-18'(r_d_q[j])) : 17'(r_d_q[j]);
            w_m0.dneg[j]   = dd[50];
            w_m0.qneg[j]   = r_d_q[j][15];
            w_m0.qmag[j]   = qm[15:0];
            // numerator 2 |D| 2^12, top bits start the remainder
            w_m0.rem[j]    = {2'b0, dmag[48:18]};
            w_m0.nlo[j]    = {dmag[17:0], 13'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[0].vld <= 1'b0;
        end else if (w_ce) begin
            r_m[0].vld <= w_m0.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m[0].op   <= w_m0.op;
            r_m[0].last <= w_m0.last;
            r_m[0].zero <= w_m0.zero;
            r_m[0].s    <= w_m0.s;
            r_m[0].root <= w_m0.root;
            r_m[0].srem <= w_m0.srem;
            r_m[0].rad  <= w_m0.rad;
            r_m[0].qneg <= w_m0.qneg;
            r_m[0].dneg <= w_m0.dneg;
            r_m[0].qmag <= w_m0.qmag;
            r_m[0].rem  <= w_m0.rem;
            r_m[0].nlo  <= w_m0.nlo;
            r_m[0].t1   <= w_m0.t1;
        end
    end

    // one divider bit per stage for every lane, one root bit in the first stages
    genvar k;
    generate
        for (k = 0; k < DSTEPS; k++) begin : g_mid
            // radicand pair consumed by this stage, unused past the sqrt steps
            localparam int RB = (k < SSTEPS) ? 49 - 2*k : 1;
            t_mid nxt;
            always_comb begin
                logic [33:0] rem2;
                logic [28:0] sr2;
                logic [28:0] trial;
                nxt = r_m[k];
                for (int j = 0; j < 4; j++) begin
                    rem2 = {r_m[k].rem[j], r_m[k].nlo[j][DSTEPS-1-k]};
                    if (rem2 >= {1'b0, r_m[k].s}) begin
                        nxt.rem[j] = 33'(rem2 - {1'b0, r_m[k].s});
                        nxt.t1[j]  = {r_m[k].t1[j][29:0], 1'b1};
                    end else begin
                        nxt.rem[j] = rem2[32:0];
                        nxt.t1[j]  = {r_m[k].t1[j][29:0], 1'b0};
                    end
                end
                sr2   = {r_m[k].srem, r_m[k].rad[RB -: 2]};
                trial = {2'b0, r_m[k].root, 2'b01};
                if (k < SSTEPS) begin
                    if (sr2 >= trial) begin
                        nxt.srem = 27'(sr2 - trial);
                        nxt.root = {r_m[k].root[NW-2:0], 1'b1};
                    end else begin
                        nxt.srem = sr2[26:0];
                        nxt.root = {r_m[k].root[NW-2:0], 1'b0};
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_m[k+1].vld <= 1'b0;
                end else if (w_ce) begin
                    r_m[k+1].vld <= nxt.vld;
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_m[k+1].op   <= nxt.op;
                    r_m[k+1].last <= nxt.last;
                    r_m[k+1].zero <= nxt.zero;
                    r_m[k+1].s    <= nxt.s;
                    r_m[k+1].root <= nxt.root;
                    r_m[k+1].srem <= nxt.srem;
                    r_m[k+1].rad  <= nxt.rad;
                    r_m[k+1].qneg <= nxt.qneg;
                    r_m[k+1].dneg <= nxt.dneg;
                    r_m[k+1].qmag <= nxt.qmag;
                    r_m[k+1].rem  <= nxt.rem;
                    r_m[k+1].nlo  <= nxt.nlo;
                    r_m[k+1].t1   <= nxt.t1;
                end
            end
        end
    endgenerate

    // scale lanes: forward scales q, backward scales the rounded projection u
    generate
        for (k = 0; k < 4; k++) begin : g_lane
            logic [31:0]   up;
            logic [XW-1:0] x;
            logic          neg;
            always_comb begin
                up  = {1'b0, r_m[DSTEPS].t1[k]} + 32'd1;
                x   = r_m[DSTEPS].op ? up[XW:1] : {{(XW-16){1'b0}}, r_m[DSTEPS].qmag[k]};
                neg = r_m[DSTEPS].op ? r_m[DSTEPS].dneg[k] : r_m[DSTEPS].qneg[k];
            end
            qn_scale u_scale (
                .i_clk  (i_clk),
                .i_ce   (w_ce),
                .i_x    (x),
                .i_neg  (neg),
                .i_n    (r_m[DSTEPS].root),
                .o_r    (w_r[k]),
                .o_clip (w_clip[k])
            );
        end
    endgenerate

    // control travels beside the scale lanes; the last entry is the output register
    generate
        for (k = 0; k < CDLY; k++) begin : g_ctl
            t_ctl src;
            if (k == 0) begin : g_first
                assign src = '{vld: r_m[DSTEPS].vld, last: r_m[DSTEPS].last,
                               zero: r_m[DSTEPS].zero};
            end else begin : g_next
                assign src = r_c_dly[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_c_dly[k].vld <= 1'b0;
                end else if (w_ce) begin
                    r_c_dly[k].vld <= src.vld;
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_ce) begin
                    r_c_dly[k].last <= src.last;
                    r_c_dly[k].zero <= src.zero;
                end
            end
        end
    endgenerate

    // zero norm forces zero data and no clip
    assign o_m_axis_tvalid = r_c_dly[CDLY-1].vld;
    assign o_m_axis_tlast  = r_c_dly[CDLY-1].last;
    assign o_m_axis_tdata  = r_c_dly[CDLY-1].zero ? 64'd0 :
                             {w_r[3], w_r[2], w_r[1], w_r[0]};
    assign o_m_axis_tuser  = {!r_c_dly[CDLY-1].zero && (|w_clip), r_c_dly[CDLY-1].zero};

    // a held output stalls the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while output held");

    // suppressed backward requests never enter the pipe
    a_drop_backward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser && !r_grad_en
        |=> !r_a_vld)
        else $error("backward request entered while gradients off");

    // front stages a and d hold while the pipe is stalled
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> $stable(r_a_vld) && $stable(r_d_vld))
        else $error("pipeline moved during stall");

    // zero norm gives zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 64'd0)
        else $error("zero norm result carries data");
endmodule

// ===== src/qn_scale.sv =====
// one lane of the final scale: rnd(x * 2^20 / n) with sign and 16-bit saturation
module qn_scale
    import qnorm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic [XW-1:0]        i_x,
    input  logic                 i_neg,
    input  logic [NW-1:0]        i_n,
    output logic signed [15:0]   o_r,
    output logic                 o_clip
);
    typedef struct packed {
        logic [NW-1:0] rem;
        logic [TW-1:0] t;
        logic          ovf;
        logic          neg;
        logic [NW-1:0] n;
    } t_sc_stage;

    t_sc_stage r_st [0:TW];
    logic signed [15:0] r_r;
    logic               r_clip;

    // load: quotient bounded by 2^17 unless the overflow check trips
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_st[0].rem <= {i_x[NW-5:0], 4'b0};
            r_st[0].t   <= '0;
            r_st[0].ovf <= ({i_x, 4'b0} >= {{(XW+4-NW){1'b0}}, i_n});
            r_st[0].neg <= i_neg;
            r_st[0].n   <= i_n;
        end
    end

    genvar k;
    generate
        for (k = 0; k < TW; k++) begin : g_step
            logic [NW:0] rem2;
            t_sc_stage   nxt;
            always_comb begin
                rem2 = {r_st[k].rem, 1'b0};
                nxt  = r_st[k];
                if (rem2 >= {1'b0, r_st[k].n}) begin
                    nxt.rem = NW'(rem2 - {1'b0, r_st[k].n});
                    nxt.t   = {r_st[k].t[TW-2:0], 1'b1};
                end else begin
                    nxt.rem = rem2[NW-1:0];
                    nxt.t   = {r_st[k].t[TW-2:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_st[k+1] <= nxt;
                end
            end
        end
    endgenerate

    // round half away from zero, then clip
    logic [TW:0]   rp;
    logic [TW-1:0] rnd;
    logic signed [15:0] n_r;
    logic               n_clip;
    always_comb begin
        rp  = {1'b0, r_st[TW].t} + {{TW{1'b0}}, 1'b1};
        rnd = rp[TW:1];
        if (!r_st[TW].neg) begin
            n_clip = r_st[TW].ovf || (rnd > TW'(32767));
            n_r    = n_clip ? 16'sh7fff : $signed(rnd[15:0]);
        end else begin
            n_clip = r_st[TW].ovf || (rnd > TW'(32768));
            n_r    = n_clip ? 16'sh8000 : $signed((~rnd[15:0]) + 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_r    <= n_r;
            r_clip <= n_clip;
        end
    end

    assign o_r    = r_r;
    assign o_clip = r_clip;
endmodule
